FILE: hdl/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
// Depends on nothing; every other file of the block but dtq_ifs uses it.
`timescale 1ns / 1ps

package dtq_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int STAMP_W = 64;
	localparam int HANDLE_W = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_INSERTED  = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_EXPIRED   = 3'd2,
		KIND_CANCELLED = 3'd3,
		KIND_NOTFOUND  = 3'd4,
		KIND_SHUTDOWN  = 3'd5
	} kind_t;

	// The stamp is the deadline for an insert and the advanced time for a tick.
	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
		logic [STAMP_W-1:0]  stamp;
		logic [7:0]          reason;
	} cmd_t;

endpackage

FILE: hdl/dtq_ifs.sv
// Request and result channel interfaces of the deadline timer queue.
// Standalone; no package is needed.
`timescale 1ns / 1ps

interface dtq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] handle;
	logic [30:0] duration;
	logic [7:0]  reason;

	modport source (output valid, output operation, output handle, output duration,
		output reason, input ready);
	modport sink (input valid, input operation, input handle, input duration,
		input reason, output ready);
endinterface

interface dtq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] out_handle;
	logic [7:0]  out_reason;
	logic        becomes_first;
	logic        last;

	modport source (output valid, output kind, output out_handle, output out_reason,
		output becomes_first, output last, input ready);
	modport sink (input valid, input kind, input out_handle, input out_reason,
		input becomes_first, input last, output ready);
endinterface

FILE: hdl/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: front end, command queue, back end.
// Depends on dtq_pkg, dtq_ifs, dtq_front, dtq_fifo and dtq_back.
//
//   channel | dir | fields
//   req     | in  | operation, handle, duration, reason
//   rsp     | out | kind, out_handle, out_reason, becomes_first, last
//
// In the back end an insert or cancel scans the pending entries: the scan
// steps over one entry per cycle until it finds the place or the end.
// A tick or flush releases head entries, one per cycle unless rsp stalls.
// Reset clears time, the entry count and the queues; no clearing pass runs.
// The front end keeps accepting until the two-entry command queue is full.
`timescale 1ns / 1ps

module deadline_timer_queue_top #(
	parameter int DEPTH = 16,
	parameter int HANDLE_BITS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);

	dtq_pkg::cmd_t push_cmd;
	dtq_pkg::cmd_t head_cmd;
	logic          push;
	logic          full;
	logic          nonempty;
	logic          pop;

	dtq_front #(.HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (push_cmd),
		.cmd_push (push),
		.cmd_full (full)
	);

	dtq_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (push_cmd),
		.push     (push),
		.full     (full),
		.rd_data  (head_cmd),
		.nonempty (nonempty),
		.pop      (pop)
	);

	dtq_back #(.DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (nonempty),
		.cmd_pop   (pop),
		.rsp       (rsp)
	);

endmodule

FILE: hdl/dtq_front.sv
// Front end: accepts request words, keeps the tick counter and forms commands.
// Depends on dtq_pkg and dtq_req_if.
`timescale 1ns / 1ps

module dtq_front #(
	parameter int HANDLE_BITS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	dtq_req_if.sink         req,
	output dtq_pkg::cmd_t   cmd,
	output logic            cmd_push,
	input  logic            cmd_full
);

	localparam int HW = (HANDLE_BITS < dtq_pkg::HANDLE_W) ? HANDLE_BITS : dtq_pkg::HANDLE_W;
	localparam logic [dtq_pkg::HANDLE_W-1:0] HMASK =
		dtq_pkg::HANDLE_W'((33'd1 << HW) - 33'd1);

	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] now_next;
	logic [TIME_BITS-1:0] deadline;
	logic [63:0]          sum;

	assign req.ready = !cmd_full;
	assign cmd_push  = req.valid && !cmd_full;

	assign sum      = 64'(now_q) + 64'(req.duration);
	assign deadline = sum[TIME_BITS-1:0];
	assign now_next = TIME_BITS'(now_q + 1'b1);

	always_comb begin
		cmd.op     = dtq_pkg::op_t'(req.operation);
		cmd.handle = req.handle & HMASK;
		cmd.reason = req.reason;
		if (dtq_pkg::op_t'(req.operation) == dtq_pkg::OP_TICK) begin
			cmd.stamp = dtq_pkg::STAMP_W'(now_next);
		end else begin
			cmd.stamp = dtq_pkg::STAMP_W'(deadline);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (cmd_push && dtq_pkg::op_t'(req.operation) == dtq_pkg::OP_TICK) begin
			now_q <= now_next;
		end
	end

endmodule

FILE: hdl/dtq_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on dtq_pkg.
`timescale 1ns / 1ps

module dtq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  dtq_pkg::cmd_t wr_data,
	input  logic          push,
	output logic          full,
	output dtq_pkg::cmd_t rd_data,
	output logic          nonempty,
	input  logic          pop
);

	dtq_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end

endmodule

FILE: hdl/dtq_back.sv
// Back end: sorted entry cells, scan and release sequencer, result register.
// Depends on dtq_pkg and dtq_rsp_if.
`timescale 1ns / 1ps

module dtq_back #(
	parameter int DEPTH = 16,
	parameter int HANDLE_BITS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dtq_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	dtq_rsp_if.source     rsp
);

	localparam int HW = (HANDLE_BITS < dtq_pkg::HANDLE_W) ? HANDLE_BITS : dtq_pkg::HANDLE_W;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = dtq_pkg::RESULT_CNT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DO, ST_REL} state_t;

	function automatic logic earlier(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] d;
		d = TIME_BITS'(a - b);
		return d[TIME_BITS-1];
	endfunction

	state_t               st_q;
	dtq_pkg::cmd_t        cmd_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        pos_q;
	logic [KW-1:0]        k_q;
	logic [DEPTH-1:0]     hit_q;
	logic [DEPTH-1:0]     hit_n;
	logic [TIME_BITS-1:0] dl_q [DEPTH];
	logic [HW-1:0]        hd_q [DEPTH];
	logic [TIME_BITS-1:0] dl_up [DEPTH];
	logic [TIME_BITS-1:0] dl_dn [DEPTH];
	logic [HW-1:0]        hd_up [DEPTH];
	logic [HW-1:0]        hd_dn [DEPTH];
	logic                 ov_q;
	dtq_pkg::kind_t       kind_q;
	logic [15:0]          handle_q;
	logic [7:0]           reason_q;
	logic                 first_q;
	logic                 last_q;

	logic [TIME_BITS-1:0] cur_stamp;
	logic                 out_free;
	logic                 is_full;
	logic                 found;
	logic                 is_tick;
	logic                 rel_go;
	logic                 rel_more;
	logic                 ins_en;
	logic                 rem_en;

	assign cur_stamp = cmd_q.stamp[TIME_BITS-1:0];
	assign out_free  = !ov_q || rsp.ready;
	assign is_full   = cnt_q == CW'(DEPTH);
	assign found     = pos_q != cnt_q;
	assign is_tick   = cmd_q.op == dtq_pkg::OP_TICK;
	assign rel_go    = (cnt_q != '0) && (k_q != KW'(dtq_pkg::MAX_RESULTS))
		&& !(is_tick && earlier(cur_stamp, dl_q[0]));
	assign rel_more  = (cnt_q != CW'(1)) && (KW'(k_q + 1'b1) != KW'(dtq_pkg::MAX_RESULTS))
		&& !(is_tick && earlier(cur_stamp, dl_q[1]));
	assign ins_en    = st_q == ST_DO && out_free && cmd_q.op == dtq_pkg::OP_INSERT && !is_full;
	assign rem_en    = (st_q == ST_DO && out_free && cmd_q.op == dtq_pkg::OP_CANCEL && found)
		|| (st_q == ST_REL && out_free && rel_go);
	assign cmd_pop   = st_q == ST_IDLE && cmd_valid;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.op == dtq_pkg::OP_INSERT) begin
				hit_n[i] = (CW'(i) < cnt_q) && earlier(cmd.stamp[TIME_BITS-1:0], dl_q[i]);
			end else begin
				hit_n[i] = (CW'(i) < cnt_q) && (hd_q[i] == cmd.handle[HW-1:0]);
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign dl_up[g] = '0;
			assign hd_up[g] = '0;
		end else begin : g_body
			assign dl_up[g] = dl_q[g-1];
			assign hd_up[g] = hd_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign dl_dn[g] = '0;
			assign hd_dn[g] = '0;
		end else begin : g_inner
			assign dl_dn[g] = dl_q[g+1];
			assign hd_dn[g] = hd_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (ins_en) begin
				if (CW'(g) == pos_q) begin
					dl_q[g] <= cur_stamp;
					hd_q[g] <= cmd_q.handle[HW-1:0];
				end else if (CW'(g) > pos_q) begin
					dl_q[g] <= dl_up[g];
					hd_q[g] <= hd_up[g];
				end
			end else if (rem_en && CW'(g) >= pos_q) begin
				dl_q[g] <= dl_dn[g];
				hd_q[g] <= hd_dn[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cmd_q    <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
			k_q      <= '0;
			hit_q    <= '0;
			ov_q     <= 1'b0;
			kind_q   <= dtq_pkg::KIND_INSERTED;
			handle_q <= '0;
			reason_q <= '0;
			first_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						pos_q <= '0;
						k_q   <= '0;
						hit_q <= hit_n;
						if (cmd.op == dtq_pkg::OP_INSERT || cmd.op == dtq_pkg::OP_CANCEL) begin
							st_q <= ST_SCAN;
						end else begin
							st_q <= ST_REL;
						end
					end
				end
				ST_SCAN: begin
					if (pos_q == cnt_q || hit_q[0]) begin
						st_q <= ST_DO;
					end else begin
						pos_q <= CW'(pos_q + 1'b1);
						hit_q <= hit_q >> 1;
					end
				end
				ST_DO: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						handle_q <= cmd_q.handle;
						last_q   <= 1'b1;
						if (cmd_q.op == dtq_pkg::OP_INSERT) begin
							reason_q <= '0;
							if (is_full) begin
								kind_q  <= dtq_pkg::KIND_FULL;
								first_q <= 1'b0;
							end else begin
								kind_q  <= dtq_pkg::KIND_INSERTED;
								first_q <= pos_q == '0;
								cnt_q   <= CW'(cnt_q + 1'b1);
							end
						end else begin
							reason_q <= cmd_q.reason;
							first_q  <= 1'b0;
							if (found) begin
								kind_q <= dtq_pkg::KIND_CANCELLED;
								cnt_q  <= CW'(cnt_q - 1'b1);
							end else begin
								kind_q <= dtq_pkg::KIND_NOTFOUND;
							end
						end
						st_q <= ST_IDLE;
					end
				end
				ST_REL: begin
					if (!rel_go) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						ov_q     <= 1'b1;
						kind_q   <= is_tick ? dtq_pkg::KIND_EXPIRED : dtq_pkg::KIND_SHUTDOWN;
						handle_q <= 16'(hd_q[0]);
						reason_q <= '0;
						first_q  <= 1'b0;
						last_q   <= !rel_more;
						cnt_q    <= CW'(cnt_q - 1'b1);
						k_q      <= KW'(k_q + 1'b1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.kind          = kind_q;
	assign rsp.out_handle    = handle_q;
	assign rsp.out_reason    = reason_q;
	assign rsp.becomes_first = first_q;
	assign rsp.last          = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SCAN |-> pos_q <= cnt_q)
		else $error("scan position beyond filled entries");

	a_full_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == dtq_pkg::KIND_FULL) |-> is_full)
		else $error("full reported while an entry is free");

endmodule

FILE: tb/deadline_timer_queue_top_tb.sv
// Self-checking testbench of the deadline timer queue: directed and random words.
// Depends on dtq_pkg, dtq_ifs and deadline_timer_queue_top.
`timescale 1ns / 1ps

module deadline_timer_queue_top_tb;

	localparam int QDEPTH = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		dtq_pkg::kind_t kind;
		logic [15:0]    handle;
		logic [7:0]     reason;
		logic           first;
		logic           last;
	} timer_event_t;

	logic clk;
	logic arst_n;
	dtq_req_if req ();
	dtq_rsp_if rsp ();

	deadline_timer_queue_top DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	timer_event_t pending_events[$];
	logic [31:0]  now_model;
	int           entry_count;
	logic [31:0]  entry_deadline[QDEPTH];
	logic [15:0]  entry_handle[QDEPTH];
	int           errors;
	int           idle_cycles;
	logic [15:0]  recent_handles[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit deadline_before(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic void push_event(dtq_pkg::kind_t k, logic [15:0] h, logic [7:0] r,
		logic f);
		timer_event_t e;
		e.kind = k;
		e.handle = h;
		e.reason = r;
		e.first = f;
		e.last = 1'b0;
		pending_events = {pending_events, e};
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < entry_count; i++) begin
			entry_deadline[i] = entry_deadline[i + 1];
			entry_handle[i] = entry_handle[i + 1];
		end
		entry_count--;
	endfunction

	function automatic void predict_timer(dtq_pkg::op_t op, logic [15:0] h, logic [30:0] dur,
		logic [7:0] r);
		int before_cnt;
		int pos;
		logic [31:0] dl;
		before_cnt = pending_events.size();
		pos = 0;
		case (op)
			dtq_pkg::OP_INSERT: begin
				if (entry_count >= QDEPTH) begin
					push_event(dtq_pkg::KIND_FULL, h, 8'd0, 1'b0);
				end else begin
					dl = now_model + {1'b0, dur};
					while (pos < entry_count && !deadline_before(dl, entry_deadline[pos]))
						pos++;
					for (int i = entry_count; i > pos; i--) begin
						entry_deadline[i] = entry_deadline[i - 1];
						entry_handle[i] = entry_handle[i - 1];
					end
					entry_deadline[pos] = dl;
					entry_handle[pos] = h;
					entry_count++;
					push_event(dtq_pkg::KIND_INSERTED, h, 8'd0, pos == 0);
				end
			end
			dtq_pkg::OP_CANCEL: begin
				while (pos < entry_count && entry_handle[pos] != h)
					pos++;
				if (pos < entry_count) begin
					drop_entry(pos);
					push_event(dtq_pkg::KIND_CANCELLED, h, r, 1'b0);
				end else begin
					push_event(dtq_pkg::KIND_NOTFOUND, h, r, 1'b0);
				end
			end
			dtq_pkg::OP_TICK: begin
				now_model = now_model + 32'd1;
				while (entry_count > 0
					&& pending_events.size() - before_cnt < dtq_pkg::MAX_RESULTS
					&& !deadline_before(now_model, entry_deadline[0])) begin
					push_event(dtq_pkg::KIND_EXPIRED, entry_handle[0], 8'd0, 1'b0);
					drop_entry(0);
				end
			end
			default: begin
				while (entry_count > 0
					&& pending_events.size() - before_cnt < dtq_pkg::MAX_RESULTS) begin
					push_event(dtq_pkg::KIND_SHUTDOWN, entry_handle[0], 8'd0, 1'b0);
					drop_entry(0);
				end
			end
		endcase
		if (pending_events.size() > before_cnt)
			pending_events[pending_events.size() - 1].last = 1'b1;
	endfunction

	// Valid stays high after an accepted word until the next word or a drain replaces it.
	task automatic send_word(dtq_pkg::op_t op, logic [15:0] h, logic [30:0] dur,
		logic [7:0] r);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.handle <= h;
		req.duration <= dur;
		req.reason <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_timer(op, h, dur, r);
	endtask

	task automatic drain_events();
		req.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected result kind %0d handle %h", $time, rsp.kind,
					rsp.out_handle);
				errors++;
			end else begin
				timer_event_t e;
				e = pending_events.pop_front();
				if (rsp.kind !== e.kind || rsp.out_handle !== e.handle
					|| rsp.out_reason !== e.reason || rsp.becomes_first !== e.first
					|| rsp.last !== e.last) begin
					$display("%0t: expected k%0d h%h r%h f%b l%b, got k%0d h%h r%h f%b l%b",
						$time, e.kind, e.handle, e.reason, e.first, e.last, rsp.kind,
						rsp.out_handle, rsp.out_reason, rsp.becomes_first, rsp.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int wait_left;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			wait_left = 0;
		end else if (rsp.ready && !rsp.valid) begin
		end else if (rsp.ready && rsp.valid) begin
			wait_left = $urandom_range(0, 5);
			if (wait_left != 0) rsp.ready <= 1'b0;
		end else if (wait_left > 0) begin
			wait_left--;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] pick_handle();
		if (recent_handles.size() != 0 && $urandom_range(0, 2) != 0)
			return recent_handles[$urandom_range(0, recent_handles.size() - 1)];
		return 16'($urandom);
	endfunction

	task automatic test_directed();
		send_word(dtq_pkg::OP_FLUSH, 16'h0000, 31'd0, 8'h00);
		send_word(dtq_pkg::OP_TICK, 16'h0000, 31'd0, 8'h00);
		send_word(dtq_pkg::OP_CANCEL, 16'hFFFF, 31'd0, 8'hFF);
		send_word(dtq_pkg::OP_INSERT, 16'hFFFF, 31'h7FFFFFFF, 8'h00);
		send_word(dtq_pkg::OP_INSERT, 16'h0000, 31'd0, 8'h00);
		send_word(dtq_pkg::OP_INSERT, 16'h1234, 31'd2, 8'h00);
		send_word(dtq_pkg::OP_INSERT, 16'h1234, 31'd2, 8'h00);
		send_word(dtq_pkg::OP_INSERT, 16'h5555, 31'd1, 8'h00);
		send_word(dtq_pkg::OP_CANCEL, 16'h1234, 31'd0, 8'hA5);
		send_word(dtq_pkg::OP_TICK, 16'h0000, 31'd0, 8'h00);
		send_word(dtq_pkg::OP_TICK, 16'h0000, 31'd0, 8'h00);
		send_word(dtq_pkg::OP_CANCEL, 16'h1234, 31'd0, 8'h5A);
		for (int i = 0; i < 15; i++)
			send_word(dtq_pkg::OP_INSERT, 16'(i), 31'(i % 3), 8'h00);
		send_word(dtq_pkg::OP_INSERT, 16'hAAAA, 31'd5, 8'h00);
		send_word(dtq_pkg::OP_TICK, 16'h0000, 31'd0, 8'h00);
		drain_events();
		send_word(dtq_pkg::OP_FLUSH, 16'h0000, 31'd0, 8'h00);
	endtask

	task automatic test_full_and_flush();
		for (int i = 0; i < 17; i++)
			send_word(dtq_pkg::OP_INSERT, 16'($urandom), 31'($urandom_range(0, 40)), 8'h00);
		send_word(dtq_pkg::OP_FLUSH, 16'h0000, 31'd0, 8'h00);
		drain_events();
	endtask

	task automatic test_random(int count);
		int pick;
		logic [15:0] h;
		logic [30:0] dur;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				h = pick_handle();
				if (recent_handles.size() > 12) void'(recent_handles.pop_front());
				recent_handles = {recent_handles, h};
				if ($urandom_range(0, 9) == 0) dur = 31'($urandom);
				else dur = 31'($urandom_range(0, 12));
				send_word(dtq_pkg::OP_INSERT, h, dur, 8'($urandom));
			end else if (pick < 60) begin
				send_word(dtq_pkg::OP_CANCEL, pick_handle(), 31'($urandom), 8'($urandom));
			end else if (pick < 97) begin
				send_word(dtq_pkg::OP_TICK, 16'($urandom), 31'($urandom), 8'($urandom));
			end else begin
				send_word(dtq_pkg::OP_FLUSH, 16'($urandom), 31'($urandom), 8'($urandom));
			end
			if (n == count / 2) drain_events();
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		now_model = 32'd0;
		entry_count = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = dtq_pkg::OP_INSERT;
		req.handle = 16'd0;
		req.duration = 31'd0;
		req.reason = 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_and_flush();
		test_random(270);
		drain_events();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: deadline_timer_queue_top.f
hdl/dtq_pkg.sv
hdl/dtq_ifs.sv
hdl/dtq_front.sv
hdl/dtq_fifo.sv
hdl/dtq_back.sv
hdl/deadline_timer_queue_top.sv
tb/deadline_timer_queue_top_tb.sv
